FILE: rtl/epd_pkg.sv
// Shared types and constants for the encoder PD wheel drive.
// Used by epd_mac, epd_div and encoder_pd_wheel_drive; no dependencies.
`default_nettype none

package epd_pkg;

  // Default encoder resolution: one turn is 2**ANGLE_BITS counts
  localparam int ANGLE_BITS_DEF = 12;

  // Multiply-accumulate operand and accumulator widths
  localparam int MAC_A_W   = 16;
  localparam int MAC_B_W   = 32;
  localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
  localparam int MAC_ACC_W = 64;

  // Divider: damping numerator over elapsed microseconds
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 16;

  // Result stream: reverse, pwm_compare, wheel_position, padded to bytes
  localparam int OUT_FIELD_W = 1 + 17 + 32;
  localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [MAC_B_W-1:0] PWM_PERIOD   = 32'd100000;
  localparam logic [MAC_B_W-1:0] US_PER_S     = 32'd1000000;
  // 60/16 gear * 256 / (2 pi * 1e6), as Q16 counts over 2**40
  localparam logic [MAC_B_W-1:0] TARGET_SCALE = 32'd167993002;

  // Shift applied to a product before it enters the accumulator
  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_32
  } epd_shift_t;

  typedef struct packed {
    logic       issue;
    logic       clear;
    epd_shift_t shift;
  } epd_mac_ctl_t;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_STIFFNESS  = 2'd0,
    REG_DAMPING    = 2'd1,
    REG_DUTY_LIMIT = 2'd2,
    REG_INVERT     = 2'd3
  } epd_reg_t;

endpackage

`default_nettype wire

FILE: rtl/encoder_pd_wheel_drive.sv
// Channel   Dir  Payload (lsb first)                              Handshake
// s_        in   raw_angle, elapsed_us, target_velocity            s_tvalid/s_tready
// m_        out  reverse, pwm_compare, wheel_position              m_tvalid/m_tready
// apb       in   stiffness, damping, duty limit, invert @ 0,4,8,C  psel/penable/pwrite
//
// The bit-serial divide of the damping term dominates the time from acceptance
// to result; the target update on the shared multiplier runs alongside it.
// The priming sample only records its angle and gives no result.
// Reset (rst, synchronous) clears position, target and the primed flag.
// s_tready is high only between samples; a finished result waits in the
// output register, and the next sample is taken while it waits.
// Top level of the encoder PD wheel drive; depends on epd_pkg, epd_mac,
// epd_div.
`default_nettype none

module encoder_pd_wheel_drive #(
  parameter int ANGLE_BITS = epd_pkg::ANGLE_BITS_DEF,
  localparam int IN_W      = ((ANGLE_BITS + 32 + 7) / 8) * 8
) (
  input  wire                       clk,
  input  wire                       rst,
  // raw_angle[ANGLE_BITS], elapsed_us[16], target_velocity[16], zero pad
  input  wire  [IN_W-1:0]           s_tdata,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  // reverse[1], pwm_compare[17], wheel_position[32], zero pad
  output logic [epd_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tvalid,
  input  wire                       m_tready,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [3:0]                paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import epd_pkg::*;

  localparam int TGT_SHIFT = 40 - ANGLE_BITS;
  localparam logic signed [ANGLE_BITS+1:0] HALF_S = (ANGLE_BITS+2)'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [ANGLE_BITS+1:0] TURN_S = (ANGLE_BITS+2)'(2 ** ANGLE_BITS);
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP, S_ERR,
    S_K_LO, S_K_HI, S_K_WAIT, S_STIFF,
    S_D_WAIT, S_US_LO, S_US_HI, S_US_WAIT, S_DIV_GO,
    S_V_WAIT, S_VS_LO, S_VS_HI, S_VS_WAIT, S_TGT,
    S_DIV_WAIT, S_DRIVE, S_PWM, S_PWM_WAIT, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [15:0] stiffness_gain;
  logic [15:0] damping_gain;
  logic [15:0] duty_limit;
  logic        invert_direction;

  // persistent state
  logic [ANGLE_BITS-1:0] previous_angle;
  logic                  primed;
  logic signed [31:0]    position_count;
  logic signed [47:0]    target_position;

  // per-sample working registers
  logic [ANGLE_BITS-1:0] angle_q;
  logic [15:0]           dt_q;
  logic                  vel_neg;
  logic [15:0]           vel_mag;
  logic signed [ANGLE_BITS:0] step_q;
  logic                  err_neg;
  logic [47:0]           err_mag;
  logic signed [40:0]    stiff_q;
  logic signed [16:0]    drive_q;

  // result register
  logic                  out_rev;
  logic [16:0]           out_pwm;
  logic signed [31:0]    out_pos;

  // shared units
  epd_mac_ctl_t           mac_ctl;
  logic [MAC_A_W-1:0]     mac_a;
  logic [MAC_B_W-1:0]     mac_b;
  logic [MAC_ACC_W-1:0]   mac_acc;
  logic                   div_start;
  logic                   div_busy;
  logic [DIV_NUM_W-1:0]   div_quo;

  epd_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  assign div_start = (state == S_DIV_GO);

  epd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mac_acc[51:16]),
    .den   (dt_q),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness_gain   <= '0;
      damping_gain     <= '0;
      duty_limit       <= 16'hFFFF;
      invert_direction <= 1'b0;
    end else if (cfg_wr) begin
      case (epd_reg_t'(paddr[3:2]))
        REG_STIFFNESS:  stiffness_gain   <= pwdata[15:0];
        REG_DAMPING:    damping_gain     <= pwdata[15:0];
        REG_DUTY_LIMIT: duty_limit       <= pwdata[15:0];
        REG_INVERT:     invert_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (epd_reg_t'(paddr[3:2]))
      REG_STIFFNESS:  prdata = {16'h0000, stiffness_gain};
      REG_DAMPING:    prdata = {16'h0000, damping_gain};
      REG_DUTY_LIMIT: prdata = {16'h0000, duty_limit};
      REG_INVERT:     prdata = {31'h0, invert_direction};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] in_angle;
  logic [15:0]           in_dt;
  logic [15:0]           in_vel;
  logic [16:0]           in_vel_abs;

  assign in_angle   = s_tdata[ANGLE_BITS-1:0];
  assign in_dt      = s_tdata[ANGLE_BITS+15:ANGLE_BITS];
  assign in_vel     = s_tdata[ANGLE_BITS+31:ANGLE_BITS+16];
  // -(-32768) still fits as a 16-bit magnitude
  assign in_vel_abs = in_vel[15] ? (17'd0 - {1'b1, in_vel}) : {1'b0, in_vel};

  assign s_tready = (state == S_IDLE);

  // ---------------------------------------------------------------------
  // Datapath around the registers
  // ---------------------------------------------------------------------
  // Unwrap: keep the step within half a turn, exact half kept as is
  logic signed [ANGLE_BITS+1:0] diff_w;
  logic signed [ANGLE_BITS+1:0] step_w;
  always_comb begin
    diff_w = $signed({2'b00, angle_q}) - $signed({2'b00, previous_angle});
    if (diff_w > HALF_S) begin
      step_w = diff_w - TURN_S;
    end else if (diff_w < -HALF_S) begin
      step_w = diff_w + TURN_S;
    end else begin
      step_w = diff_w;
    end
  end

  // Saturating position update
  logic signed [32:0] pos_sum;
  logic signed [31:0] pos_next;
  always_comb begin
    pos_sum = $signed({position_count[31], position_count})
            + $signed({{(32-ANGLE_BITS){step_w[ANGLE_BITS]}}, step_w[ANGLE_BITS:0]});
    if (pos_sum[32] != pos_sum[31]) begin
      pos_next = pos_sum[32] ? POS_MIN : POS_MAX;
    end else begin
      pos_next = pos_sum[31:0];
    end
  end

  // Position error in Q16 counts, saturated to 48 bits, split to sign/magnitude
  logic signed [48:0] err_w;
  logic signed [47:0] err_sat;
  always_comb begin
    err_w = $signed({target_position[47], target_position})
          - $signed({position_count[31], position_count, 16'h0000});
    if (err_w[48] != err_w[47]) begin
      err_sat = err_w[48] ? Q48_MIN : Q48_MAX;
    end else begin
      err_sat = err_w[47:0];
    end
  end

  logic [ANGLE_BITS:0] step_abs;
  assign step_abs = step_q[ANGLE_BITS] ? (~step_q + 1'b1) : step_q;

  // Stiffness term: K * |err| / 2**24, sign restored (truncates toward zero)
  logic signed [40:0] stiff_w;
  assign stiff_w = err_neg ? -$signed({1'b0, mac_acc[63:24]})
                           :  $signed({1'b0, mac_acc[63:24]});

  // Drive = stiff - damp, clamped to +/- duty limit
  logic signed [36:0] damp_w;
  logic signed [41:0] drive_w;
  logic signed [41:0] lim_w;
  logic signed [16:0] drive_next;
  always_comb begin
    damp_w  = step_q[ANGLE_BITS] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    drive_w = $signed({stiff_q[40], stiff_q}) - $signed({{5{damp_w[36]}}, damp_w});
    lim_w   = $signed({26'h0, duty_limit});
    if (drive_w > lim_w) begin
      drive_next = $signed({1'b0, duty_limit});
    end else if (drive_w < -lim_w) begin
      drive_next = -$signed({1'b0, duty_limit});
    end else begin
      drive_next = drive_w[16:0];
    end
  end

  // Target advance: |v| * dt * scale >> shift, sign applied, saturated
  logic [MAC_ACC_W-1:0] inc_full;
  logic signed [49:0]   tgt_sum;
  logic signed [49:0]   inc_s;
  logic signed [47:0]   tgt_next;
  always_comb begin
    inc_full = mac_acc >> TGT_SHIFT;
    inc_s    = $signed({1'b0, inc_full[48:0]});
    tgt_sum  = $signed({{2{target_position[47]}}, target_position})
             + (vel_neg ? -inc_s : inc_s);
    if (tgt_sum > $signed({{2{Q48_MAX[47]}}, Q48_MAX})) begin
      tgt_next = Q48_MAX;
    end else if (tgt_sum < $signed({{2{Q48_MIN[47]}}, Q48_MIN})) begin
      tgt_next = Q48_MIN;
    end else begin
      tgt_next = tgt_sum[47:0];
    end
  end

  // Reported position, mirrored when inverted
  logic signed [31:0] pos_report;
  always_comb begin
    if (!invert_direction) begin
      pos_report = position_count;
    end else if (position_count == POS_MIN) begin
      pos_report = POS_MAX;
    end else begin
      pos_report = -position_count;
    end
  end

  // ---------------------------------------------------------------------
  // Multiplier schedule. A product issued in one state is registered with
  // its controls and then added into the accumulator, so a state may read the
  // previous result while it issues the next product.
  // ---------------------------------------------------------------------
  always_comb begin
    mac_ctl.issue = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.shift = SH_0;
    mac_a         = '0;
    mac_b         = '0;
    case (state)
      S_K_LO: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = stiffness_gain;
        mac_b         = err_mag[31:0];
      end
      S_K_HI: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.shift = SH_32;
        mac_a         = stiffness_gain;
        mac_b         = {16'h0000, err_mag[47:32]};
      end
      S_STIFF: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = damping_gain;
        mac_b         = {{(31-ANGLE_BITS){1'b0}}, step_abs};
      end
      S_US_LO: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = mac_acc[15:0];
        mac_b         = US_PER_S;
      end
      S_US_HI: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.shift = SH_16;
        mac_a         = mac_acc[31:16];
        mac_b         = US_PER_S;
      end
      S_DIV_GO: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = dt_q;
        mac_b         = {16'h0000, vel_mag};
      end
      S_VS_LO: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = mac_acc[15:0];
        mac_b         = TARGET_SCALE;
      end
      S_VS_HI: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.shift = SH_16;
        mac_a         = mac_acc[31:16];
        mac_b         = TARGET_SCALE;
      end
      S_PWM: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = drive_q[15:0];   // 65536 + drive when negative
        mac_b         = PWM_PERIOD;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      primed          <= 1'b0;
      previous_angle  <= '0;
      position_count  <= '0;
      target_position <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      // S_OUT decides m_tvalid itself when it loads a new result
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (!primed) begin
              previous_angle <= in_angle;
              primed         <= 1'b1;
            end else begin
              angle_q <= in_angle;
              dt_q    <= (in_dt == 16'h0000) ? 16'h0001 : in_dt;
              vel_mag <= in_vel_abs[15:0];
              vel_neg <= in_vel[15] ^ invert_direction;
              state   <= S_STEP;
            end
          end
        end
        S_STEP: begin
          step_q         <= step_w[ANGLE_BITS:0];
          previous_angle <= angle_q;
          position_count <= pos_next;
          state          <= S_ERR;
        end
        S_ERR: begin
          err_neg <= err_sat[47];
          err_mag <= err_sat[47] ? (~err_sat + 1'b1) : err_sat;
          state   <= S_K_LO;
        end
        S_K_LO:    state <= S_K_HI;
        S_K_HI:    state <= S_K_WAIT;
        S_K_WAIT:  state <= S_STIFF;
        S_STIFF: begin
          stiff_q <= stiff_w;
          state   <= S_D_WAIT;
        end
        S_D_WAIT:  state <= S_US_LO;
        S_US_LO:   state <= S_US_HI;
        S_US_HI:   state <= S_US_WAIT;
        S_US_WAIT: state <= S_DIV_GO;
        S_DIV_GO:  state <= S_V_WAIT;
        S_V_WAIT:  state <= S_VS_LO;
        S_VS_LO:   state <= S_VS_HI;
        S_VS_HI:   state <= S_VS_WAIT;
        S_VS_WAIT: state <= S_TGT;
        S_TGT: begin
          target_position <= tgt_next;
          state           <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!div_busy) begin
            state <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          drive_q <= drive_next;
          state   <= S_PWM;
        end
        S_PWM:      state <= S_PWM_WAIT;
        S_PWM_WAIT: state <= S_OUT;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_rev  <= drive_q[16];
            out_pwm  <= mac_acc[32:16];
            out_pos  <= pos_report;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {{(OUT_W-OUT_FIELD_W){1'b0}}, out_pos, out_pwm, out_rev};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider still running between samples");

  a_no_result_unprimed: assert property (@(posedge clk) disable iff (rst)
    !primed |-> !m_tvalid)
    else $error("result presented before priming sample");

  a_prime_only: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !primed) |=> (primed && state == S_IDLE))
    else $error("priming sample started a computation");

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_PWM) |->
      (drive_q <= $signed({1'b0, duty_limit}) && drive_q >= -$signed({1'b0, duty_limit})))
    else $error("drive outside duty limit");

  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({15'h0, out_pwm} <= PWM_PERIOD))
    else $error("pwm compare beyond period");

endmodule

`default_nettype wire

FILE: rtl/epd_mac.sv
// Shared 16x32 multiplier with a 64-bit accumulator, one product per cycle.
// Depends on epd_pkg. Product is registered, then added into the registered accumulator.
`default_nettype none

module epd_mac (
  input  wire                           clk,
  input  wire                           rst,
  input  epd_pkg::epd_mac_ctl_t         ctl,
  input  wire  [epd_pkg::MAC_A_W-1:0]   a,
  input  wire  [epd_pkg::MAC_B_W-1:0]   b,
  output logic [epd_pkg::MAC_ACC_W-1:0] acc
);
  import epd_pkg::*;

  logic [MAC_P_W-1:0]   prod;
  logic                 vld_q;
  logic                 clr_q;
  epd_shift_t           shift_q;
  logic [MAC_ACC_W-1:0] addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q   <= 1'b0;
      clr_q   <= 1'b0;
      shift_q <= SH_0;
    end else begin
      vld_q   <= ctl.issue;
      clr_q   <= ctl.clear;
      shift_q <= ctl.shift;
    end
  end

  always_ff @(posedge clk) begin
    prod <= {{MAC_B_W{1'b0}}, a} * {{MAC_A_W{1'b0}}, b};
  end

  always_comb begin
    case (shift_q)
      SH_0:    addend = {{(MAC_ACC_W-MAC_P_W){1'b0}}, prod};
      SH_16:   addend = {prod, 16'h0000};
      SH_32:   addend = {prod[31:0], 32'h0000_0000};
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vld_q) begin
      acc <= (clr_q ? '0 : acc) + addend;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/epd_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on epd_pkg for operand widths.
`default_nettype none

module epd_div (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire  [epd_pkg::DIV_NUM_W-1:0] num,
  input  wire  [epd_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [epd_pkg::DIV_NUM_W-1:0] quo
);
  import epd_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire
